/* rtl/core/circular_deque_assert.svh */
// Assertion macros for the circular deque, clocked on clk and disabled in reset.
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CDQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("circular_deque: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CDQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("circular_deque: next-cycle check failed");

`endif

/* rtl/core/cdq_pkg.sv */
// Shared types and constants for the circular deque.
package cdq_pkg;

  localparam int CAP_BITS      = 5;
  localparam int CAP_MAX       = 31;
  localparam int OUT_BITS      = 32;
  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK       = 3'd4
  } cdq_op_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic shift_up;    // take left neighbor (push at front)
    logic shift_down;  // take right neighbor (pop at front)
    logic load_tail;   // cell at the fill level takes the new word
  } cdq_cell_ctrl_t;

endpackage

/* rtl/core/cdq_cell.sv */
// One storage cell of the deque chain: holds a word and trades with its neighbors.
module cdq_cell #(
  parameter int WIDTH = 32,
  parameter int CNT_W = 5,
  parameter int IDX   = 0
) (
  input  logic                   clk,
  input  cdq_pkg::cdq_cell_ctrl_t ctrl,
  input  logic [CNT_W-1:0]       cnt,
  input  logic [WIDTH-1:0]       left_d,
  input  logic [WIDTH-1:0]       right_d,
  input  logic [WIDTH-1:0]       tail_d,
  output logic [WIDTH-1:0]       data_q
);

  logic [WIDTH-1:0] data_r;
  logic             at_tail;

  assign at_tail = (cnt == CNT_W'(IDX));

  always_ff @(posedge clk) begin
    if (ctrl.shift_up) begin
      data_r <= left_d;
    end else if (ctrl.shift_down) begin
      data_r <= right_d;
    end else if (ctrl.load_tail && at_tail) begin
      data_r <= tail_d;
    end
  end

  assign data_q = data_r;

endmodule

/* rtl/core/circular_deque.sv */
// Top level of the circular deque: control, fill count and the cell chain.
//
// A double-ended queue of signed words. Assert start with in_opcode and
// in_push_value; the command is taken at a clock edge where start is high
// and busy is low. Opcodes push at front, push at back, pop at front, pop at
// back and peek. The cycle after each transfer, out_valid pulses for one
// cycle with out_ok, the front and rear words (all ones when empty) and the
// empty and full flags as they stand after the command. A new command may be
// given every cycle: the chain of cells shifts by one position per cycle, so
// any command completes in a single step. Contents sit packed in the chain
// with the front in cell 0; the rear is picked by the fill count. cfg_we
// writes cfg_wdata into the capacity register (0 acts as 1, values above
// DEPTH act as DEPTH) and empties the deque; write it only while no command
// is outstanding. Reset empties the deque, sets capacity to 16 and holds
// busy high while rst_n is low. Results cannot be stalled by the receiver.
module circular_deque #(
  parameter int DEPTH     = cdq_pkg::DEPTH_DEF,
  parameter int WORD_BITS = cdq_pkg::WORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        in_opcode,
  input  logic signed [cdq_pkg::OUT_BITS-1:0] in_push_value,
  output logic                              out_valid,
  output logic                              out_ok,
  output logic signed [cdq_pkg::OUT_BITS-1:0] out_front_value,
  output logic signed [cdq_pkg::OUT_BITS-1:0] out_rear_value,
  output logic                              out_is_empty,
  output logic                              out_is_full,
  input  logic                              cfg_we,
  input  logic [cdq_pkg::CAP_BITS-1:0]      cfg_wdata
);
  import cdq_pkg::*;

  `include "circular_deque_assert.svh"

  // Capacity cannot exceed the 5-bit register, so no more cells are usable.
  localparam int NCELL = (DEPTH < CAP_MAX) ? DEPTH : CAP_MAX;
  localparam int CNT_W = $clog2(NCELL + 1);
  localparam int IDX_W = (NCELL > 1) ? $clog2(NCELL) : 1;
  localparam int CW    = (WORD_BITS < OUT_BITS) ? WORD_BITS : OUT_BITS;

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CAP_BITS-1:0] capacity_r;
  logic                busy_r;
  logic                out_valid_r;
  logic                ok_r, ok_nxt;

  logic [CW-1:0]       cell_data [NCELL];
  logic [CW-1:0]       push_word;
  cdq_cell_ctrl_t      ctrl;
  cdq_op_t             op;
  logic                acc;
  logic [CAP_BITS-1:0] eff_cap;
  logic [CAP_BITS-1:0] cnt_ext;
  logic                full, empty;
  logic [CNT_W-1:0]    rear_pos;
  logic                front_push;

  assign op        = cdq_op_t'(in_opcode);
  assign acc       = start && !busy_r;
  assign push_word = in_push_value[CW-1:0];

  always_comb begin
    if (capacity_r == '0) begin
      eff_cap = CAP_BITS'(1);
    end else if (capacity_r > CAP_BITS'(NCELL)) begin
      eff_cap = CAP_BITS'(NCELL);
    end else begin
      eff_cap = capacity_r;
    end
  end

  assign cnt_ext = CAP_BITS'(count_r);
  assign full    = (cnt_ext >= eff_cap);
  assign empty   = (count_r == '0);

  always_comb begin
    ctrl      = '0;
    ok_nxt    = 1'b0;
    count_nxt = count_r;
    case (op)
      OP_PUSH_FRONT: begin
        ok_nxt        = !full;
        ctrl.shift_up = acc && !full;
        if (!full) count_nxt = count_r + CNT_W'(1);
      end
      OP_PUSH_BACK: begin
        ok_nxt         = !full;
        ctrl.load_tail = acc && !full;
        if (!full) count_nxt = count_r + CNT_W'(1);
      end
      OP_POP_FRONT: begin
        ok_nxt          = !empty;
        ctrl.shift_down = acc && !empty;
        if (!empty) count_nxt = count_r - CNT_W'(1);
      end
      OP_POP_BACK: begin
        ok_nxt = !empty;
        if (!empty) count_nxt = count_r - CNT_W'(1);
      end
      OP_PEEK: begin
        ok_nxt = 1'b1;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  // Chain: cell 0 takes the pushed word on a front push, the last cell
  // reloads itself on a front pop (its value is past the fill level).
  genvar gi;
  generate
    for (gi = 0; gi < NCELL; gi++) begin : g_cell
      logic [CW-1:0] left_w, right_w;
      if (gi == 0) begin : g_first
        assign left_w = push_word;
      end else begin : g_mid
        assign left_w = cell_data[gi-1];
      end
      if (gi == NCELL - 1) begin : g_last
        assign right_w = cell_data[gi];
      end else begin : g_inner
        assign right_w = cell_data[gi+1];
      end
      cdq_cell #(
        .WIDTH (CW),
        .CNT_W (CNT_W),
        .IDX   (gi)
      ) u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .cnt     (count_r),
        .left_d  (left_w),
        .right_d (right_w),
        .tail_d  (push_word),
        .data_q  (cell_data[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      capacity_r  <= CAP_RESET;
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      out_valid_r <= acc;
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
        count_r    <= '0;
      end else if (acc) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    ok_r <= ok_nxt;
  end

  assign rear_pos        = count_r - CNT_W'(1);
  assign busy            = busy_r;
  assign out_valid       = out_valid_r;
  assign out_ok          = ok_r;
  assign out_is_empty    = empty;
  assign out_is_full     = full;
  assign out_front_value = empty ? '1 : OUT_BITS'(signed'(cell_data[0]));
  assign out_rear_value  = empty ? '1
                                 : OUT_BITS'(signed'(cell_data[rear_pos[IDX_W-1:0]]));

  assign front_push = acc && (op == OP_PUSH_FRONT) && !full && !cfg_we;

  `CDQ_ASSERT_NEXT(a_result_follows, acc, out_valid)
  `CDQ_ASSERT_NOW(a_count_in_range, 1'b1, cnt_ext <= eff_cap)
  `CDQ_ASSERT_NOW(a_empty_not_full, out_valid && out_is_empty, !out_is_full)
  `CDQ_ASSERT_NEXT(a_front_push_lands, front_push, cell_data[0] == $past(push_word))

endmodule
